>>> hw/rtl/hrvs_pkg.sv
// ----------------------------------------------------------------------------
// hrvs_pkg
// Shared types, constants and the arctangent table for the heading-relative
// velocity step pipeline.
// ----------------------------------------------------------------------------
package hrvs_pkg;

    // Defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int ROTATE_STAGES_DEF = 16;
    localparam int MAX_STAGES        = 24;

    // First Q4.28 squared length that counts as movement (0.01)
    localparam logic [31:0] MOVE_THRESH = 32'd2684355;
    // CORDIC gain compensation, Q0.32
    localparam logic [31:0] GAIN_INV    = 32'h9B74EDA9;

    // Datapath widths
    localparam int SQ_REM_W = 36;
    localparam int ROT_W    = 34;
    localparam int RES_W    = 33;

    // atan(2^-i) in 2^32 units per turn
    localparam logic [31:0] ATAN_TURN32 [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    // Table entry rounded half up to the angle precision
    function automatic logic [31:0] atan_quant(int idx, int angle_bits);
        logic [32:0] e;
        int          s;
        s = 32 - angle_bits;
        e = {1'b0, ATAN_TURN32[idx]} + (33'd1 << (s - 1));
        e = (e >> s) << s;
        return e[31:0];
    endfunction

    // Input item
    typedef struct packed {
        logic signed [15:0] strafe_in;
        logic signed [15:0] forward_in;
        logic        [15:0] speed_in;
        logic        [15:0] heading_in;
    } in_item_t;

    // Result item
    typedef struct packed {
        logic signed [15:0] x_velocity_delta;
        logic signed [15:0] z_velocity_delta;
        logic               moved_flag;
    } out_item_t;

    // Sideband that rides along the root and divide chains
    typedef struct packed {
        logic        sign_x;
        logic        sign_z;
        logic [31:0] phase;
        logic        moved;
    } side_t;

    // Square-root cell payload
    typedef struct packed {
        side_t                 side;
        logic [30:0]           px;
        logic [30:0]           pz;
        logic [31:0]           rad;
        logic [SQ_REM_W-1:0]   rem;
        logic [31:0]           root;
    } sqrt_pl_t;

    // Divider cell payload, two lanes sharing one divisor
    typedef struct packed {
        side_t       side;
        logic [31:0] r;
        logic [31:0] rem_x;
        logic [31:0] nq_x;
        logic [31:0] rem_z;
        logic [31:0] nq_z;
    } div_pl_t;

    // Rotation cell payload
    typedef struct packed {
        logic signed [ROT_W-1:0] x;
        logic signed [ROT_W-1:0] z;
        logic signed [RES_W-1:0] res;
        logic                    moved;
    } rot_pl_t;

endpackage

>>> hw/rtl/hrvs_sqrt_cell.sv
// ----------------------------------------------------------------------------
// hrvs_sqrt_cell
// One step of a digit-by-digit square root: two radicand bits in, one root
// bit out, registered.
// ----------------------------------------------------------------------------
module hrvs_sqrt_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               up_valid,
    input  hrvs_pkg::sqrt_pl_t up,
    output logic               dn_valid,
    output hrvs_pkg::sqrt_pl_t dn
);
    import hrvs_pkg::*;

    logic                dn_valid_reg;
    sqrt_pl_t            dn_reg;
    sqrt_pl_t            dn_next;
    logic [SQ_REM_W-1:0] shifted;
    logic [SQ_REM_W-1:0] trial;

    // Trial subtract of (4*root + 1)
    always_comb
    begin
        shifted = {up.rem[SQ_REM_W-3:0], up.rad[31:30]};
        trial   = {{(SQ_REM_W-34){1'b0}}, up.root, 2'b01};
        dn_next = up;
        dn_next.rad = {up.rad[29:0], 2'b00};
        if (shifted >= trial)
        begin
            dn_next.rem  = shifted - trial;
            dn_next.root = {up.root[30:0], 1'b1};
        end
        else
        begin
            dn_next.rem  = shifted;
            dn_next.root = {up.root[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_valid_reg <= 1'b0;
        else if (en)
            dn_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dn_reg <= dn_next;
    end

    assign dn_valid = dn_valid_reg;
    assign dn       = dn_reg;

endmodule

>>> hw/rtl/hrvs_div_cell.sv
// ----------------------------------------------------------------------------
// hrvs_div_cell
// One restoring-division step for both lanes: one quotient bit each, shared
// divisor, registered.
// ----------------------------------------------------------------------------
module hrvs_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              up_valid,
    input  hrvs_pkg::div_pl_t up,
    output logic              dn_valid,
    output hrvs_pkg::div_pl_t dn
);
    import hrvs_pkg::*;

    logic        dn_valid_reg;
    div_pl_t     dn_reg;
    div_pl_t     dn_next;
    logic [32:0] tx;
    logic [32:0] tz;
    logic        bx;
    logic        bz;

    // Shift in the next numerator bit, compare against the divisor
    always_comb
    begin
        tx = {up.rem_x, up.nq_x[31]};
        tz = {up.rem_z, up.nq_z[31]};
        bx = (tx >= {1'b0, up.r});
        bz = (tz >= {1'b0, up.r});
        dn_next = up;
        dn_next.rem_x = bx ? 32'(tx - {1'b0, up.r}) : tx[31:0];
        dn_next.rem_z = bz ? 32'(tz - {1'b0, up.r}) : tz[31:0];
        dn_next.nq_x  = {up.nq_x[30:0], bx};
        dn_next.nq_z  = {up.nq_z[30:0], bz};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_valid_reg <= 1'b0;
        else if (en)
            dn_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dn_reg <= dn_next;
    end

    assign dn_valid = dn_valid_reg;
    assign dn       = dn_reg;

endmodule

>>> hw/rtl/hrvs_cordic_cell.sv
// ----------------------------------------------------------------------------
// hrvs_cordic_cell
// One CORDIC rotation micro-step with a fixed shift and a fixed angle,
// registered.
// ----------------------------------------------------------------------------
module hrvs_cordic_cell #(
    parameter int IDX        = 0,
    parameter int ANGLE_BITS = hrvs_pkg::ANGLE_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              up_valid,
    input  hrvs_pkg::rot_pl_t up,
    output logic              dn_valid,
    output hrvs_pkg::rot_pl_t dn
);
    import hrvs_pkg::*;

    localparam logic [31:0] ANG = atan_quant(IDX, ANGLE_BITS);

    logic                    dn_valid_reg;
    rot_pl_t                 dn_reg;
    rot_pl_t                 dn_next;
    logic signed [ROT_W-1:0] dx;
    logic signed [ROT_W-1:0] dz;
    logic signed [RES_W-1:0] ang;

    // Rotate toward zero residual
    always_comb
    begin
        dx  = up.z >>> IDX;
        dz  = up.x >>> IDX;
        ang = $signed({1'b0, ANG});
        dn_next = up;
        if (!up.res[RES_W-1])
        begin
            dn_next.x   = up.x - dx;
            dn_next.z   = up.z + dz;
            dn_next.res = up.res - ang;
        end
        else
        begin
            dn_next.x   = up.x + dx;
            dn_next.z   = up.z - dz;
            dn_next.res = up.res + ang;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dn_valid_reg <= 1'b0;
        else if (en)
            dn_valid_reg <= up_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dn_reg <= dn_next;
    end

    assign dn_valid = dn_valid_reg;
    assign dn       = dn_reg;

endmodule

>>> hw/rtl/heading_relative_velocity_step_unit.sv
// ----------------------------------------------------------------------------
// heading_relative_velocity_step_unit
// Rescales an intent vector to a given speed and rotates it by a heading;
// square root, divide and CORDIC are each a chain of one-bit/one-step cells.
// ----------------------------------------------------------------------------
// Pipeline: 1 front, 32 root cells, 1 prep, 32 divide cells, 1 gain,
//   1 quadrant, the rotation cells and the output register.
// Throughput: one item per cycle; the whole chain holds only while the
//   output skid register is occupied.
// Reset: asynchronous, clears all valid bits; no clearing pass.
module heading_relative_velocity_step_unit #(
    parameter int ANGLE_BITS    = hrvs_pkg::ANGLE_BITS_DEF,
    parameter int ROTATE_STAGES = hrvs_pkg::ROTATE_STAGES_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  hrvs_pkg::in_item_t  cmd,
    output logic                res_valid,
    input  logic                res_ready,
    output hrvs_pkg::out_item_t res
);
    import hrvs_pkg::*;

    localparam int NROT = (ROTATE_STAGES > MAX_STAGES) ? MAX_STAGES : ROTATE_STAGES;
    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);

    typedef struct packed {
        logic [31:0] gx;
        logic [31:0] gz;
        logic        sign_x;
        logic        sign_z;
        logic [31:0] phase;
        logic        moved;
    } gain_pl_t;

    logic en;

    // ---------------- front: squares and products ----------------
    logic               front_valid_reg;
    sqrt_pl_t           front_reg;
    sqrt_pl_t           front_next;
    logic signed [31:0] sq_x;
    logic signed [31:0] sq_z;
    logic        [32:0] d2;
    logic        [15:0] mag_x;
    logic        [15:0] mag_z;
    logic        [31:0] prod_x;
    logic        [31:0] prod_z;

    always_comb
    begin
        sq_x   = cmd.strafe_in * cmd.strafe_in;
        sq_z   = cmd.forward_in * cmd.forward_in;
        d2     = {1'b0, sq_x} + {1'b0, sq_z};
        mag_x  = cmd.strafe_in[15] ? 16'(-cmd.strafe_in) : cmd.strafe_in;
        mag_z  = cmd.forward_in[15] ? 16'(-cmd.forward_in) : cmd.forward_in;
        prod_x = mag_x * cmd.speed_in;
        prod_z = mag_z * cmd.speed_in;
        front_next.side.sign_x = cmd.strafe_in[15];
        front_next.side.sign_z = cmd.forward_in[15];
        front_next.side.phase  = {cmd.heading_in, 16'h0000} & PHASE_MASK;
        front_next.side.moved  = (d2 >= {1'b0, MOVE_THRESH});
        front_next.px   = prod_x[30:0];
        front_next.pz   = prod_z[30:0];
        front_next.rad  = d2[31:0];
        front_next.rem  = '0;
        front_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            front_valid_reg <= 1'b0;
        else if (en)
            front_valid_reg <= cmd_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            front_reg <= front_next;
    end

    // ---------------- square-root chain ----------------
    logic     sq_valid [33];
    sqrt_pl_t sq_pl    [33];

    assign sq_valid[0] = front_valid_reg;
    assign sq_pl[0]    = front_reg;

    for (genvar i = 0; i < 32; i++)
    begin : g_sqrt
        hrvs_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (sq_valid[i]),
            .up       (sq_pl[i]),
            .dn_valid (sq_valid[i+1]),
            .dn       (sq_pl[i+1])
        );
    end

    // ---------------- prep: rounded numerators ----------------
    logic        prep_valid_reg;
    div_pl_t     prep_reg;
    div_pl_t     prep_next;
    logic [61:0] num_x;
    logic [61:0] num_z;

    always_comb
    begin
        num_x = {1'b0, sq_pl[32].px, 30'b0} + {31'b0, sq_pl[32].root[31:1]};
        num_z = {1'b0, sq_pl[32].pz, 30'b0} + {31'b0, sq_pl[32].root[31:1]};
        prep_next.side  = sq_pl[32].side;
        prep_next.r     = sq_pl[32].root;
        prep_next.rem_x = {2'b00, num_x[61:32]};
        prep_next.nq_x  = num_x[31:0];
        prep_next.rem_z = {2'b00, num_z[61:32]};
        prep_next.nq_z  = num_z[31:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            prep_valid_reg <= 1'b0;
        else if (en)
            prep_valid_reg <= sq_valid[32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            prep_reg <= prep_next;
    end

    // ---------------- divide chain ----------------
    logic    dv_valid [33];
    div_pl_t dv_pl    [33];

    assign dv_valid[0] = prep_valid_reg;
    assign dv_pl[0]    = prep_reg;

    for (genvar i = 0; i < 32; i++)
    begin : g_div
        hrvs_div_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (dv_valid[i]),
            .up       (dv_pl[i]),
            .dn_valid (dv_valid[i+1]),
            .dn       (dv_pl[i+1])
        );
    end

    // ---------------- gain compensation ----------------
    logic        gain_valid_reg;
    gain_pl_t    gain_reg;
    gain_pl_t    gain_next;
    logic [64:0] gprod_x;
    logic [64:0] gprod_z;

    always_comb
    begin
        // full 64-bit product, rounded half up before taking the top word
        gprod_x = {33'd0, dv_pl[32].nq_x} * {33'd0, GAIN_INV} + (65'd1 << 31);
        gprod_z = {33'd0, dv_pl[32].nq_z} * {33'd0, GAIN_INV} + (65'd1 << 31);
        gain_next.gx     = gprod_x[63:32];
        gain_next.gz     = gprod_z[63:32];
        gain_next.sign_x = dv_pl[32].side.sign_x;
        gain_next.sign_z = dv_pl[32].side.sign_z;
        gain_next.phase  = dv_pl[32].side.phase;
        gain_next.moved  = dv_pl[32].side.moved;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gain_valid_reg <= 1'b0;
        else if (en)
            gain_valid_reg <= dv_valid[32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            gain_reg <= gain_next;
    end

    // ---------------- sign restore and quarter turns ----------------
    logic                    quad_valid_reg;
    rot_pl_t                 quad_reg;
    rot_pl_t                 quad_next;
    logic signed [ROT_W-1:0] vx;
    logic signed [ROT_W-1:0] vz;

    always_comb
    begin
        vx = $signed({2'b00, gain_reg.gx});
        vz = $signed({2'b00, gain_reg.gz});
        if (gain_reg.sign_x)
            vx = -vx;
        if (gain_reg.sign_z)
            vz = -vz;
        unique case (gain_reg.phase[31:30])
            2'd0:
            begin
                quad_next.x = vx;
                quad_next.z = vz;
            end
            2'd1:
            begin
                quad_next.x = -vz;
                quad_next.z = vx;
            end
            2'd2:
            begin
                quad_next.x = -vx;
                quad_next.z = -vz;
            end
            default:
            begin
                quad_next.x = vz;
                quad_next.z = -vx;
            end
        endcase
        quad_next.res   = $signed({3'b000, gain_reg.phase[29:0]});
        quad_next.moved = gain_reg.moved;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quad_valid_reg <= 1'b0;
        else if (en)
            quad_valid_reg <= gain_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            quad_reg <= quad_next;
    end

    // ---------------- CORDIC chain ----------------
    logic    rt_valid [NROT+1];
    rot_pl_t rt_pl    [NROT+1];

    assign rt_valid[0] = quad_valid_reg;
    assign rt_pl[0]    = quad_reg;

    for (genvar i = 0; i < NROT; i++)
    begin : g_rot
        hrvs_cordic_cell #(
            .IDX        (i),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .up_valid (rt_valid[i]),
            .up       (rt_pl[i]),
            .dn_valid (rt_valid[i+1]),
            .dn       (rt_pl[i+1])
        );
    end

    // ---------------- round to Q2.14 and saturate ----------------
    out_item_t               fin;
    logic signed [ROT_W:0]   rx;
    logic signed [ROT_W:0]   rz;
    logic signed [ROT_W-16:0] qx;
    logic signed [ROT_W-16:0] qz;

    always_comb
    begin
        rx = (ROT_W+1)'(rt_pl[NROT].x) + (ROT_W+1)'(32768);
        rz = (ROT_W+1)'(rt_pl[NROT].z) + (ROT_W+1)'(32768);
        qx = rx[ROT_W:16];
        qz = rz[ROT_W:16];
        if (qx > 32767)
            fin.x_velocity_delta = 16'sh7FFF;
        else if (qx < -32768)
            fin.x_velocity_delta = 16'sh8000;
        else
            fin.x_velocity_delta = qx[15:0];
        if (qz > 32767)
            fin.z_velocity_delta = 16'sh7FFF;
        else if (qz < -32768)
            fin.z_velocity_delta = 16'sh8000;
        else
            fin.z_velocity_delta = qz[15:0];
        fin.moved_flag = rt_pl[NROT].moved;
        // short vector: no velocity change
        if (!rt_pl[NROT].moved)
        begin
            fin.x_velocity_delta = '0;
            fin.z_velocity_delta = '0;
        end
    end

    // ---------------- output register and skid ----------------
    logic      out_valid_reg;
    out_item_t out_reg;
    logic      skid_valid_reg;
    out_item_t skid_reg;
    logic      arrive;
    logic      take;

    assign en     = !skid_valid_reg;
    assign arrive = en && rt_valid[NROT];
    assign take   = out_valid_reg && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_valid_reg && !res_ready)
        begin
            if (arrive)
                skid_valid_reg <= 1'b1;
        end
        else if (skid_valid_reg)
        begin
            out_valid_reg  <= 1'b1;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= arrive;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_valid_reg && !res_ready)
        begin
            if (arrive)
                skid_reg <= fin;
        end
        else if (skid_valid_reg)
            out_reg <= skid_reg;
        else if (arrive)
            out_reg <= fin;
    end

    assign cmd_ready = en;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // ---------------- assertions ----------------
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds an item while output register is empty");

    a_still_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.moved_flag |->
            res.x_velocity_delta == 16'sd0 && res.z_velocity_delta == 16'sd0)
        else $error("short vector item carries a nonzero delta");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        take && skid_valid_reg |=> out_valid_reg && !skid_valid_reg)
        else $error("skid item not moved to output after a take");

    a_take_frees: assert property (@(posedge clk) disable iff (!rst_n)
        take && !skid_valid_reg && !arrive |=> !out_valid_reg)
        else $error("output stays valid after its item was taken");

endmodule

>>> test/tb_heading_relative_velocity_step_unit.sv
// ----------------------------------------------------------------------------
// tb_heading_relative_velocity_step_unit
// Sends intent vectors with speed and heading through the unit. A bit-exact
// predictor computes the scaled and rotated deltas for each accepted item,
// and each result is checked in order. Both sides stall at random.
// ----------------------------------------------------------------------------
module tb_heading_relative_velocity_step_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import hrvs_pkg::*;

    localparam int ANG_BITS  = ANGLE_BITS_DEF;
    localparam int STAGES    = ROTATE_STAGES_DEF;
    localparam int IDLE_LIMIT = 4000;

    logic      clk;
    logic      rst_n;
    logic      cmd_valid;
    logic      cmd_ready;
    in_item_t  cmd;
    logic      res_valid;
    logic      res_ready;
    out_item_t res;

    out_item_t expected_deltas[$];
    int        send_idle_pct;
    int        recv_idle_pct;
    int        items_sent;
    int        results_checked;
    int        moved_count;
    int        fail_count;
    int        quiet_cycles;

    heading_relative_velocity_step_unit #(
        .ANGLE_BITS    (ANG_BITS),
        .ROTATE_STAGES (STAGES)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Floor of the square root of a 64-bit value
    function automatic bit [63:0] root_floor(bit [63:0] v);
        bit [63:0] acc;
        bit [63:0] b;
        acc = 0;
        b   = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= acc + b)
            begin
                v   = v - (acc + b);
                acc = (acc >> 1) + b;
            end
            else
                acc = acc >> 1;
            b = b >> 2;
        end
        return acc;
    endfunction

    // Component scaled to the target speed, gain compensated, Q2.30
    function automatic longint scale_component(int c, bit [15:0] spd, bit [63:0] len);
        bit [63:0] mag;
        bit [63:0] q;
        mag = (c < 0) ? 64'(-c) : 64'(c);
        q   = (mag * spd) << 30;
        q   = (q + (len >> 1)) / len;
        q   = (q * 64'(GAIN_INV) + (64'd1 << 31)) >> 32;
        return (c < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic logic signed [15:0] q14_saturate(longint v);
        longint o;
        o = (v + 32768) >>> 16;
        if (o > 32767)
            o = 32767;
        if (o < -32768)
            o = -32768;
        return o[15:0];
    endfunction

    // Expected velocity deltas for one item
    function automatic out_item_t velocity_step(in_item_t it);
        out_item_t o;
        int        sx;
        int        sz;
        bit [63:0] d2;
        bit [63:0] len;
        bit [63:0] a;
        bit [31:0] phase;
        bit [63:0] e;
        longint    x;
        longint    z;
        longint    t;
        longint    resid;
        longint    dx;
        longint    dz;
        int        sh;
        sx = it.strafe_in;
        sz = it.forward_in;
        o  = '0;
        d2 = 64'(longint'(sx) * sx + longint'(sz) * sz);
        if (d2 < 64'(MOVE_THRESH))
            return o;
        len = root_floor(d2 << 32);
        x   = scale_component(sx, it.speed_in, len);
        z   = scale_component(sz, it.speed_in, len);
        sh  = 32 - ANG_BITS;
        if (ANG_BITS >= 16)
            a = 64'(it.heading_in) << (ANG_BITS - 16);
        else
            a = 64'(it.heading_in) >> (16 - ANG_BITS);
        phase = 32'(a << sh);
        // whole quarter turns first
        for (int k = 0; k < int'(phase[31:30]); k++)
        begin
            t = x;
            x = -z;
            z = t;
        end
        resid = longint'(phase[29:0]);
        for (int i = 0; i < STAGES && i < MAX_STAGES; i++)
        begin
            e = 64'(ATAN_TURN32[i]);
            if (sh > 0)
                e = ((e + (64'd1 << (sh - 1))) >> sh) << sh;
            dx = z >>> i;
            dz = x >>> i;
            if (resid >= 0)
            begin
                x     = x - dx;
                z     = z + dz;
                resid = resid - longint'(e);
            end
            else
            begin
                x     = x + dx;
                z     = z - dz;
                resid = resid + longint'(e);
            end
        end
        o.x_velocity_delta = q14_saturate(x);
        o.z_velocity_delta = q14_saturate(z);
        o.moved_flag       = 1'b1;
        return o;
    endfunction

    // Record the expectation for every accepted item
    always @(posedge clk)
    begin
        if (rst_n && cmd_valid && cmd_ready)
        begin
            expected_deltas.push_back(velocity_step(cmd));
            items_sent++;
        end
    end

    // Result side: random back-pressure and in-order comparison
    always @(posedge clk)
    begin
        out_item_t want;
        res_ready <= ($urandom_range(99) >= recv_idle_pct);
        if (rst_n && res_valid && res_ready)
        begin
            if (expected_deltas.size() == 0)
            begin
                $error("unexpected result x=%0d z=%0d moved=%0b",
                       res.x_velocity_delta, res.z_velocity_delta, res.moved_flag);
                fail_count++;
            end
            else
            begin
                want = expected_deltas.pop_front();
                results_checked++;
                if (want.moved_flag)
                    moved_count++;
                if (res.x_velocity_delta !== want.x_velocity_delta)
                begin
                    $error("x_velocity_delta expected %0d got %0d",
                           want.x_velocity_delta, res.x_velocity_delta);
                    fail_count++;
                end
                if (res.z_velocity_delta !== want.z_velocity_delta)
                begin
                    $error("z_velocity_delta expected %0d got %0d",
                           want.z_velocity_delta, res.z_velocity_delta);
                    fail_count++;
                end
                if (res.moved_flag !== want.moved_flag)
                begin
                    $error("moved_flag expected %0b got %0b",
                           want.moved_flag, res.moved_flag);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("timeout: %0d results still expected", expected_deltas.size());
            $display("tb_heading_relative_velocity_step_unit failed");
            $finish;
        end
    end

    // Send one item, with an optional random gap in front of it
    task automatic send_item(in_item_t it);
        if ($urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        cmd       <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (!cmd_ready)
            @(posedge clk);
    endtask

    function automatic in_item_t make_item(int s, int f, int spd, int hd);
        in_item_t it;
        it.strafe_in  = s[15:0];
        it.forward_in = f[15:0];
        it.speed_in   = spd[15:0];
        it.heading_in = hd[15:0];
        return it;
    endfunction

    task automatic wait_drained();
        cmd_valid <= 1'b0;
        while (expected_deltas.size() != 0)
            @(posedge clk);
    endtask

    // Extremes, quadrant headings, threshold edge and zero speed
    task automatic test_directed();
        send_item(make_item(0, 0, 16'hFFFF, 0));
        send_item(make_item(1638, 36, 16'hFFFF, 0));
        send_item(make_item(1638, 37, 16'hFFFF, 0));
        send_item(make_item(-1638, -37, 16'h8000, 16'h1234));
        send_item(make_item(16384, 0, 0, 16'h4000));
        send_item(make_item(-32768, -32768, 16'hFFFF, 0));
        send_item(make_item(32767, 32767, 16'hFFFF, 16'hFFFF));
        send_item(make_item(-32768, 32767, 16'hFFFF, 16'h8000));
        send_item(make_item(32767, -32768, 16'hFFFF, 16'hC000));
        send_item(make_item(0, 16384, 16'hFFFF, 16'h4000));
        send_item(make_item(0, -32768, 16'hFFFF, 16'h2000));
        send_item(make_item(-32768, 0, 16'hFFFF, 16'hE000));
        send_item(make_item(16384, 16384, 16'h0001, 16'h6000));
        send_item(make_item(100, 32767, 16'hFFFF, 16'hA000));
        send_item(make_item(32767, 1, 16'hFFFF, 16'h0001));
        send_item(make_item(-1, -32768, 16'h7FFF, 16'hFFFE));
        send_item(make_item(5000, -5000, 16'hAAAA, 16'h5555));
        wait_drained();
    endtask

    // Mostly moving vectors, with short ones near the threshold mixed in
    task automatic test_random(int n);
        int s;
        int f;
        int spd;
        for (int k = 0; k < n; k++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    s = $urandom_range(3400) - 1700;
                    f = $urandom_range(3400) - 1700;
                end
                1:
                begin
                    s = $urandom_range(2000) - 1000;
                    f = $urandom_range(1) ? 1638 : -1638;
                end
                default:
                begin
                    s = int'($signed(16'($urandom)));
                    f = int'($signed(16'($urandom)));
                end
            endcase
            case ($urandom_range(9))
                0: spd = 0;
                1: spd = 16'hFFFF;
                default: spd = $urandom_range(16'hFFFF);
            endcase
            send_item(make_item(s, f, spd, $urandom_range(16'hFFFF)));
        end
        cmd_valid <= 1'b0;
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cmd_valid     = 1'b0;
        cmd           = '0;
        res_ready     = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        items_sent      = 0;
        results_checked = 0;
        moved_count     = 0;
        fail_count      = 0;
        quiet_cycles    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        send_idle_pct = 38;
        recv_idle_pct = 61;
        test_random(500);
        wait_drained();
        send_idle_pct = 61;
        recv_idle_pct = 38;
        test_random(500);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(530);

        wait_drained();
        repeat (150) @(posedge clk);
        $display("covered %0d items, %0d results checked (%0d moved), quadrants",
                 items_sent, results_checked, moved_count);
        $display("threshold edge, zero speed and saturation under random stalls");
        if (fail_count == 0 && expected_deltas.size() == 0)
            $display("tb_heading_relative_velocity_step_unit passed");
        else
            $display("tb_heading_relative_velocity_step_unit failed");
        $finish;
    end

endmodule

>>> sim.f
hw/rtl/hrvs_pkg.sv
hw/rtl/hrvs_sqrt_cell.sv
hw/rtl/hrvs_div_cell.sv
hw/rtl/hrvs_cordic_cell.sv
hw/rtl/heading_relative_velocity_step_unit.sv
test/tb_heading_relative_velocity_step_unit.sv
